// ----- src/four_level_page_table_manager_top_assert.svh -----
// Assertion macros for the page table manager.
// Included by the top level; no other dependencies.
`ifndef FOUR_LEVEL_PAGE_TABLE_MANAGER_TOP_ASSERT_SVH
`define FOUR_LEVEL_PAGE_TABLE_MANAGER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define FLPTM_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("flptm check failed");
`define FLPTM_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("flptm check failed");
`else
`define FLPTM_ASSERT(lbl, prop)
`define FLPTM_ASSERT_NEXT(lbl, pre, post)
`endif
`endif

// ----- src/flptm_pkg.sv -----
// Shared types and constants of the page table manager.
// No dependencies.
package flptm_pkg;
  localparam int unsigned CntW = 11;

  localparam logic [1:0] OP_MAP       = 2'd0;
  localparam logic [1:0] OP_UNMAP     = 2'd1;
  localparam logic [1:0] OP_TRANSLATE = 2'd2;
  localparam logic [1:0] OP_NOP       = 2'd3;

  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_NOT_MAPPED = 2'd1;
  localparam logic [1:0] ST_NO_FRAME   = 2'd2;

  localparam logic [1:0] LVL_LEAF = 2'd3;

  localparam logic [7:0] CFG_POOL_BASE = 8'd0;
  localparam logic [7:0] CFG_INT_FLAGS = 8'd1;

  typedef struct packed {
    logic       clr_we;
    logic       load_in;
    logic [1:0] level;
    logic       descend;
    logic       alloc;
    logic       leaf_map;
    logic       leaf_unmap;
    logic       load_phys;
    logic       st_we;
    logic [1:0] st_val;
    logic       load_out;
  } cmd_t;

  typedef struct packed {
    logic       clr_last;
    logic [1:0] op;
    logic       entry_ok;
    logic       leaf_present;
    logic       pool_full;
    logic       out_free;
  } sts_t;
endpackage

// ----- src/flptm_ctrl.sv -----
// Sequencer for clear, walk and update of the page table manager.
// Depends on flptm_pkg.
module flptm_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  flptm_pkg::sts_t sts_i,
  output flptm_pkg::cmd_t cmd_o
);
  import flptm_pkg::*;

  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_RD   = 3'd2;
  localparam logic [2:0] S_EV   = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0] state_q, state_d;
  logic [1:0] level_q, level_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    level_d = level_q;
    cmd_o = '0;
    cmd_o.level = level_q;
    unique case (state_q)
      S_CLR: begin
        cmd_o.clr_we = 1'b1;
        if (sts_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          level_d = 2'd0;
          state_d = S_RD;
        end
      end
      S_RD: begin
        if (sts_i.op == OP_NOP) state_d = S_DONE;
        else state_d = S_EV;
      end
      S_EV: begin
        state_d = S_DONE;
        if (level_q != LVL_LEAF) begin
          priority if (sts_i.entry_ok) begin
            cmd_o.descend = 1'b1;
            level_d = level_q + 2'd1;
            state_d = S_RD;
          end else if (sts_i.op != OP_MAP) begin
            cmd_o.st_we = 1'b1;
            cmd_o.st_val = ST_NOT_MAPPED;
          end else if (sts_i.pool_full) begin
            cmd_o.st_we = 1'b1;
            cmd_o.st_val = ST_NO_FRAME;
          end else begin
            cmd_o.alloc = 1'b1;
            level_d = level_q + 2'd1;
            state_d = S_RD;
          end
        end else begin
          priority if (sts_i.op == OP_MAP) begin
            cmd_o.leaf_map = 1'b1;
          end else if (!sts_i.leaf_present) begin
            cmd_o.st_we = 1'b1;
            cmd_o.st_val = ST_NOT_MAPPED;
          end else if (sts_i.op == OP_UNMAP) begin
            cmd_o.leaf_unmap = 1'b1;
          end else begin
            cmd_o.load_phys = 1'b1;
          end
        end
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_CLR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
      level_q <= 2'd0;
    end else begin
      state_q <= state_d;
      level_q <= level_d;
    end
  end
endmodule

// ----- src/flptm_dp.sv -----
// Datapath: table store, walk registers, counters, config and result register.
// Depends on flptm_pkg.
module flptm_dp #(
  parameter int unsigned TABLE_FRAMES = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  flptm_pkg::cmd_t cmd_i,
  output flptm_pkg::sts_t sts_o,
  input  logic [1:0]      opcode_i,
  input  logic [47:0]     vaddr_i,
  input  logic [51:0]     paddr_i,
  input  logic [63:0]     flags_i,
  input  logic            cfg_we_i,
  input  logic [7:0]      cfg_index_i,
  input  logic [39:0]     cfg_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [1:0]      status_o,
  output logic [51:0]     phys_out_o,
  output logic [15:0]     mapped_count_o,
  output logic [flptm_pkg::CntW-1:0] tables_used_o
);
  import flptm_pkg::*;

  localparam int unsigned TW    = $clog2(TABLE_FRAMES);
  localparam int unsigned AW    = TW + 9;
  localparam int unsigned Depth = TABLE_FRAMES * 512;
  localparam logic [AW-1:0] LastAddr = AW'(Depth - 1);
  localparam logic [CntW-1:0] FramesL = CntW'(TABLE_FRAMES);

  logic [63:0]   mem [Depth];
  logic [63:0]   rdata_q;
  logic [AW-1:0] clr_q, addr, waddr;
  logic [63:0]   wdata;
  logic          we;

  logic [1:0]  op_q;
  logic [47:0] va_q;
  logic [51:0] pa_q;
  logic [63:0] fl_q;
  logic [TW-1:0] tbl_q;
  logic [CntW-1:0] nfree_q;
  logic [15:0] cnt_q;
  logic [39:0] base_q;
  logic [11:0] iflags_q;
  logic [1:0]  st_q;
  logic [51:0] pout_q;
  logic        ov_q;
  logic [1:0]  ost_q;
  logic [51:0] opout_q;
  logic [15:0] ocnt_q;
  logic [CntW-1:0] onfree_q;

  logic [8:0]  idx;
  logic [39:0] off, new_frame;

  always_comb begin
    unique case (cmd_i.level)
      2'd0: idx = va_q[47:39];
      2'd1: idx = va_q[38:30];
      2'd2: idx = va_q[29:21];
      default: idx = va_q[20:12];
    endcase
  end

  assign addr = {tbl_q, idx};
  assign off = rdata_q[51:12] - base_q;
  assign new_frame = base_q + 40'(nfree_q);

  always_comb begin
    we = 1'b0;
    waddr = addr;
    wdata = '0;
    priority if (cmd_i.clr_we) begin
      we = 1'b1;
      waddr = clr_q;
    end else if (cmd_i.alloc) begin
      we = 1'b1;
      wdata = {12'd0, new_frame, iflags_q[11:1], 1'b1};
    end else if (cmd_i.leaf_map) begin
      we = 1'b1;
      wdata = {fl_q[63:52], pa_q[51:12], fl_q[11:1], 1'b1};
    end else if (cmd_i.leaf_unmap) begin
      we = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    rdata_q <= mem[addr];
  end

  assign sts_o.clr_last     = (clr_q == LastAddr);
  assign sts_o.op           = op_q;
  assign sts_o.entry_ok     = rdata_q[0] && (off < 40'(nfree_q));
  assign sts_o.leaf_present = rdata_q[0];
  assign sts_o.pool_full    = (nfree_q >= FramesL);
  assign sts_o.out_free     = !ov_q || out_ready_i;

  // Walk payload and result registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      op_q <= opcode_i;
      va_q <= vaddr_i;
      pa_q <= paddr_i;
      fl_q <= flags_i;
    end
    if (cmd_i.load_out) begin
      ost_q    <= st_q;
      opout_q  <= pout_q;
      ocnt_q   <= cnt_q;
      onfree_q <= nfree_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q    <= '0;
      tbl_q    <= '0;
      nfree_q  <= CntW'(1);
      cnt_q    <= '0;
      base_q   <= 40'd256;
      iflags_q <= 12'd3;
      st_q     <= ST_OK;
      pout_q   <= '0;
      ov_q     <= 1'b0;
    end else begin
      if (cmd_i.clr_we) clr_q <= clr_q + AW'(1);
      if (cfg_we_i && cfg_index_i == CFG_POOL_BASE) base_q <= cfg_data_i;
      if (cfg_we_i && cfg_index_i == CFG_INT_FLAGS) iflags_q <= cfg_data_i[11:0];
      if (cmd_i.load_in) begin
        tbl_q  <= '0;
        st_q   <= ST_OK;
        pout_q <= '0;
      end
      if (cmd_i.descend) tbl_q <= off[TW-1:0];
      if (cmd_i.alloc) begin
        tbl_q   <= nfree_q[TW-1:0];
        nfree_q <= nfree_q + CntW'(1);
      end
      if (cmd_i.leaf_map && !rdata_q[0]) cnt_q <= cnt_q + 16'd1;
      if (cmd_i.leaf_unmap) cnt_q <= cnt_q - 16'd1;
      if (cmd_i.load_phys) pout_q <= {rdata_q[51:12], va_q[11:0]};
      if (cmd_i.st_we) st_q <= cmd_i.st_val;
      if (cmd_i.load_out) ov_q <= 1'b1;
      else if (out_ready_i) ov_q <= 1'b0;
    end
  end

  assign out_valid_o    = ov_q;
  assign status_o       = ost_q;
  assign phys_out_o     = opout_q;
  assign mapped_count_o = ocnt_q;
  assign tables_used_o  = onfree_q;
endmodule

// ----- src/four_level_page_table_manager_top.sv -----
// Four-level page table manager: map, unmap and translate over an internal table store.
// Each level walks through a read state and an evaluate state; a done state then loads the result
// register once it is free, so the result waits while a previous result waits on m_axis_tready_i.
// Items are taken one at a time: a new input is accepted only after the result is loaded, the unused
// opcode skips the evaluate state, and the walk is serialised by the dependent table reads.
// Reset: a clearing pass zeroes all TABLE_FRAMES*512 entries before the first input is accepted.
module four_level_page_table_manager_top #(
  parameter int unsigned TABLE_FRAMES = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // opcode[1:0], vaddr[49:2], paddr[101:50], flags[165:102], zero pad
  input  logic [167:0] s_axis_tdata_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // status[1:0], phys_out[53:2], mapped_count[69:54], tables_used[80:70], zero pad
  output logic [87:0]  m_axis_tdata_o,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [7:0]   cfg_index_i,
  input  logic [39:0]  cfg_data_i
);
  import flptm_pkg::*;
  `include "four_level_page_table_manager_top_assert.svh"

  cmd_t cmd;
  sts_t sts;
  logic [1:0]  status;
  logic [51:0] phys_out;
  logic [15:0] mapped_count;
  logic [CntW-1:0] tables_used;

  assign cfg_ready_o = 1'b1;

  flptm_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  flptm_dp #(.TABLE_FRAMES(TABLE_FRAMES)) u_dp (
    .clk_i,
    .rst_ni,
    .cmd_i          (cmd),
    .sts_o          (sts),
    .opcode_i       (s_axis_tdata_i[1:0]),
    .vaddr_i        (s_axis_tdata_i[49:2]),
    .paddr_i        (s_axis_tdata_i[101:50]),
    .flags_i        (s_axis_tdata_i[165:102]),
    .cfg_we_i       (cfg_valid_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .out_valid_o    (m_axis_tvalid_o),
    .out_ready_i    (m_axis_tready_i),
    .status_o       (status),
    .phys_out_o     (phys_out),
    .mapped_count_o (mapped_count),
    .tables_used_o  (tables_used)
  );

  assign m_axis_tdata_o = {7'd0, tables_used, mapped_count, phys_out, status};

  `FLPTM_ASSERT(a_tables_bound, !m_axis_tvalid_o || (tables_used <= CntW'(TABLE_FRAMES)))
  `FLPTM_ASSERT(a_phys_ok, !m_axis_tvalid_o || phys_out == 52'd0 || status == ST_OK)
  `FLPTM_ASSERT_NEXT(a_no_accept_busy, s_axis_tvalid_i && s_axis_tready_o, !s_axis_tready_o)
endmodule
